// ----- hdl/typed_value_scan_filter_core_macros.svh -----
// Assertion macros for the typed value scan filter core.
// Included by RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef TYPED_VALUE_SCAN_FILTER_CORE_MACROS_SVH
`define TYPED_VALUE_SCAN_FILTER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// checked only out of reset
`define TVSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define TVSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TVSF_ASSERT(lbl, prop, msg)
`define TVSF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/tvsf_pkg.sv -----
// Shared types, codes and helper functions for the typed value scan filter.
// No dependencies; the modules refer to it by scoped names.
package tvsf_pkg;

  // value types
  localparam logic [3:0] VT_U8  = 4'd0;
  localparam logic [3:0] VT_U16 = 4'd1;
  localparam logic [3:0] VT_U32 = 4'd2;
  localparam logic [3:0] VT_U64 = 4'd3;
  localparam logic [3:0] VT_I8  = 4'd4;
  localparam logic [3:0] VT_I16 = 4'd5;
  localparam logic [3:0] VT_I32 = 4'd6;
  localparam logic [3:0] VT_I64 = 4'd7;
  localparam logic [3:0] VT_F32 = 4'd8;
  localparam logic [3:0] VT_F64 = 4'd9;

  // comparison modes
  localparam logic [3:0] MODE_EQ        = 4'd0;
  localparam logic [3:0] MODE_NE        = 4'd1;
  localparam logic [3:0] MODE_GT        = 4'd2;
  localparam logic [3:0] MODE_GTE       = 4'd3;
  localparam logic [3:0] MODE_LT        = 4'd4;
  localparam logic [3:0] MODE_LTE       = 4'd5;
  localparam logic [3:0] MODE_INC       = 4'd6;
  localparam logic [3:0] MODE_INC_BY    = 4'd7;
  localparam logic [3:0] MODE_DEC       = 4'd8;
  localparam logic [3:0] MODE_DEC_BY    = 4'd9;
  localparam logic [3:0] MODE_CHG       = 4'd10;
  localparam logic [3:0] MODE_CHG_BY    = 4'd11;
  localparam logic [3:0] MODE_UNCHANGED = 4'd12;
  localparam logic [3:0] MODE_UNKNOWN   = 4'd13;

  // result status
  localparam logic [1:0] ST_HIT       = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd1;
  localparam logic [1:0] ST_NEED_PREV = 2'd2;
  localparam logic [1:0] ST_NEED_VAL  = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_TYPE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMP_MODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_KIND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_BITS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_VALID = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HITS     = 3'd5;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [63:0] F64_QNAN = 64'h7FF8_0000_0000_0000;

  typedef enum logic [1:0] {
    CK_INT = 2'd0,
    CK_F32 = 2'd1,
    CK_F64 = 2'd2
  } cvt_kind_t;

  typedef struct packed {
    logic [3:0]  value_type;
    logic [3:0]  comparison_mode;
    logic        pass_kind;
    logic [63:0] needle_bits;
    logic        needle_valid;
    logic [20:0] max_hits;
  } cfg_t;

  // operand for the to-double converter
  typedef struct packed {
    cvt_kind_t   kind;
    logic        sgn;
    logic [63:0] mag;
  } cvt_in_t;

  // one classified word, front to back
  typedef struct packed {
    logic [1:0]  status;
    logic        read_ok;
    logic        use_prev;
    logic        isf;
    logic [3:0]  mode;
    logic [31:0] address;
    logic [63:0] raw;
    logic [63:0] nraw;
    logic [63:0] prev;
    cvt_in_t     cv;
    cvt_in_t     cn;
  } item_t;

  function automatic logic [3:0] lzc16(input logic [15:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) r = 4'(15 - i);
    end
    return r;
  endfunction

  // join per-16-bit leading zero counts, chunk 3 is the top
  function automatic logic [5:0] lz_join(input logic [3:0][3:0] cl, input logic [3:0] nz);
    logic [5:0] r;
    if (nz[3])      r = {2'd0, cl[3]};
    else if (nz[2]) r = {2'd1, cl[2]};
    else if (nz[1]) r = {2'd2, cl[1]};
    else            r = {2'd3, cl[0]};
    return r;
  endfunction

  function automatic logic f_nan(input logic [63:0] a);
    return (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
  endfunction

  function automatic logic f_eq(input logic [63:0] a, input logic [63:0] b);
    return !f_nan(a) && !f_nan(b) &&
           ((a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)));
  endfunction

  function automatic logic f_lt(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ka;
    logic [63:0] kb;
    ka = a[63] ? ~a : {1'b1, a[62:0]};
    kb = b[63] ? ~b : {1'b1, b[62:0]};
    return !f_nan(a) && !f_nan(b) &&
           !((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) && (ka < kb);
  endfunction

endpackage

// ----- hdl/tvsf_in_if.sv -----
// Input word channel: valid/ready plus one memory word.
// Standalone; no package use.
interface tvsf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic [63:0] value_bits;
  logic [63:0] previous_value;
  logic        read_ok;
  modport source (output valid, address, value_bits, previous_value, read_ok, input ready);
  modport sink   (input valid, address, value_bits, previous_value, read_ok, output ready);
endinterface

// ----- hdl/tvsf_out_if.sv -----
// Result channel: valid/ready plus one hit or error status.
// Standalone; no package use.
interface tvsf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] hit_address;
  logic [63:0] hit_raw;
  logic [63:0] hit_numeric;
  logic        limit_reached;
  modport source (output valid, status, hit_address, hit_raw, hit_numeric, limit_reached,
                  input ready);
  modport sink   (input valid, status, hit_address, hit_raw, hit_numeric, limit_reached,
                  output ready);
endinterface

// ----- hdl/tvsf_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and data.
// Standalone; no package use.
interface tvsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/tvsf_fifo.sv -----
// Short queue of classified words between the front and back parts.
// Depends on tvsf_pkg (item_t, FIFO_DEPTH).
module tvsf_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  tvsf_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output tvsf_pkg::item_t pop_item
);

  tvsf_pkg::item_t mem_r [tvsf_pkg::FIFO_DEPTH];
  logic [tvsf_pkg::FIFO_AW-1:0] wp_r, rp_r;
  logic [tvsf_pkg::FIFO_AW:0]   cnt_r;
  logic do_push, do_pop;

  assign push_ready = (cnt_r != (tvsf_pkg::FIFO_AW+1)'(tvsf_pkg::FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- hdl/tvsf_cvt.sv -----
// Three-stage converter of integer magnitudes and f32/f64 words to IEEE double.
// Depends on tvsf_pkg (cvt_in_t, lzc16, lz_join).
module tvsf_cvt (
  input  logic               clk,
  input  logic               en,
  input  tvsf_pkg::cvt_in_t  din,
  output logic [63:0]        dout
);

  // stage 1: classify, chunked leading-zero count
  logic [63:0] m_c, res_c;
  logic [10:0] base_c;
  logic        sgn_c, spec_c;
  logic [7:0]  ex;
  logic [22:0] man;
  logic [3:0][3:0] cl_c;
  logic [3:0]  nz_c;

  logic [63:0] s1_m_r, s1_res_r;
  logic [10:0] s1_base_r;
  logic        s1_sgn_r, s1_spec_r;
  logic [3:0][3:0] s1_cl_r;
  logic [3:0]  s1_nz_r;

  always_comb begin
    m_c    = '0;
    res_c  = '0;
    base_c = '0;
    sgn_c  = din.sgn;
    spec_c = 1'b0;
    ex     = din.mag[30:23];
    man    = din.mag[22:0];
    case (din.kind)
      tvsf_pkg::CK_F64: begin
        spec_c = 1'b1;
        res_c  = din.mag;
      end
      tvsf_pkg::CK_F32: begin
        sgn_c = din.mag[31];
        if (ex == 8'hFF) begin
          spec_c = 1'b1;
          res_c  = {din.mag[31], 11'h7FF, man | ((man != 23'd0) ? 23'h400000 : 23'd0),
                    29'd0};
        end else if (ex != 8'd0) begin
          spec_c = 1'b1;
          res_c  = {din.mag[31], {3'd0, ex} + 11'd896, man, 29'd0};
        end else if (man == 23'd0) begin
          spec_c = 1'b1;
          res_c  = {din.mag[31], 63'd0};
        end else begin
          // subnormal: renormalize like an integer
          m_c    = {man, 41'd0};
          base_c = 11'd896;
        end
      end
      tvsf_pkg::CK_INT: begin
        if (din.mag == 64'd0) begin
          spec_c = 1'b1;
        end else begin
          m_c    = din.mag;
          base_c = 11'd1086;
        end
      end
      default: spec_c = 1'b1;
    endcase
    for (int c = 0; c < 4; c++) begin
      cl_c[c] = tvsf_pkg::lzc16(m_c[16*c +: 16]);
      nz_c[c] = |m_c[16*c +: 16];
    end
  end

  // stage 2: normalize
  logic [5:0]  lz_c;
  logic [63:0] s2_n_r, s2_res_r;
  logic [10:0] s2_e_r;
  logic        s2_sgn_r, s2_spec_r;

  assign lz_c = tvsf_pkg::lz_join(s1_cl_r, s1_nz_r);

  // stage 3: round to nearest even, pack
  logic [52:0] fr_c;
  logic        inc_c;
  logic [10:0] e3_c;

  assign inc_c = s2_n_r[10] && ((|s2_n_r[9:0]) || s2_n_r[11]);
  assign fr_c  = {1'b0, s2_n_r[62:11]} + {52'd0, inc_c};
  assign e3_c  = s2_e_r + {10'd0, fr_c[52]};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m_r    <= m_c;
      s1_res_r  <= res_c;
      s1_base_r <= base_c;
      s1_sgn_r  <= sgn_c;
      s1_spec_r <= spec_c;
      s1_cl_r   <= cl_c;
      s1_nz_r   <= nz_c;

      s2_n_r    <= s1_m_r << lz_c;
      s2_e_r    <= s1_base_r - {5'd0, lz_c};
      s2_res_r  <= s1_res_r;
      s2_sgn_r  <= s1_sgn_r;
      s2_spec_r <= s1_spec_r;

      dout <= s2_spec_r ? s2_res_r : {s2_sgn_r, e3_c, fr_c[51:0]};
    end
  end

endmodule

// ----- hdl/tvsf_fsub.sv -----
// Six-stage IEEE double subtractor, a - b, round to nearest even.
// Depends on tvsf_pkg (lzc16, lz_join, F64_QNAN).
module tvsf_fsub (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] dout
);

  // stage 1: unpack, specials, order by magnitude
  logic [63:0] bn;
  logic [10:0] ea, eb, eea, eeb, ebig, esml;
  logic        nan_a, nan_b, inf_a, inf_b, swap;
  logic        spec_c;
  logic [63:0] sval_c;
  logic [52:0] mbig, msml;

  assign bn    = {~b[63], b[62:0]};
  assign ea    = a[62:52];
  assign eb    = bn[62:52];
  assign nan_a = (ea == 11'h7FF) && (a[51:0] != 52'd0);
  assign nan_b = (eb == 11'h7FF) && (bn[51:0] != 52'd0);
  assign inf_a = (ea == 11'h7FF) && (a[51:0] == 52'd0);
  assign inf_b = (eb == 11'h7FF) && (bn[51:0] == 52'd0);
  assign eea   = (ea == 11'd0) ? 11'd1 : ea;
  assign eeb   = (eb == 11'd0) ? 11'd1 : eb;
  assign swap  = bn[62:0] > a[62:0];
  assign ebig  = swap ? eeb : eea;
  assign esml  = swap ? eea : eeb;
  assign mbig  = swap ? {eb != 11'd0, bn[51:0]} : {ea != 11'd0, a[51:0]};
  assign msml  = swap ? {ea != 11'd0, a[51:0]} : {eb != 11'd0, bn[51:0]};

  always_comb begin
    spec_c = 1'b1;
    sval_c = tvsf_pkg::F64_QNAN;
    if (nan_a || nan_b) begin
      sval_c = tvsf_pkg::F64_QNAN;
    end else if (inf_a && inf_b) begin
      sval_c = (a[63] != bn[63]) ? tvsf_pkg::F64_QNAN : a;
    end else if (inf_a) begin
      sval_c = a;
    end else if (inf_b) begin
      sval_c = bn;
    end else begin
      spec_c = 1'b0;
    end
  end

  logic        s1_spec_r, s1_sgn_r, s1_sub_r;
  logic [63:0] s1_val_r;
  logic [10:0] s1_e_r, s1_diff_r;
  logic [52:0] s1_mb_r, s1_ms_r;

  // stage 2: align smaller operand with sticky
  logic [55:0] mbs, al_c;
  logic        lost;
  always_comb begin
    mbs  = {s1_ms_r, 3'd0};
    lost = 1'b0;
    if (s1_diff_r >= 11'd56) begin
      al_c = {55'd0, |s1_ms_r};
    end else begin
      lost = |(mbs & ~({56{1'b1}} << s1_diff_r[5:0]));
      al_c = mbs >> s1_diff_r[5:0];
      al_c[0] = al_c[0] | lost;
    end
  end

  logic        s2_spec_r, s2_sgn_r, s2_sub_r;
  logic [63:0] s2_val_r;
  logic [10:0] s2_e_r;
  logic [55:0] s2_ma_r, s2_mb_r;

  // stage 3: add or subtract
  logic        s3_spec_r, s3_sgn_r;
  logic [63:0] s3_val_r;
  logic [10:0] s3_e_r;
  logic [56:0] s3_sum_r;

  // stage 4: carry fold, chunked leading-zero count
  logic [55:0] n4_c;
  logic [11:0] e4_c;
  logic [3:0][3:0] cl_c;
  logic [3:0]  nz_c;
  logic [63:0] n4_pad;
  always_comb begin
    if (s3_sum_r[56]) begin
      n4_c = {s3_sum_r[56:2], |s3_sum_r[1:0]};
      e4_c = {1'b0, s3_e_r} + 12'd1;
    end else begin
      n4_c = s3_sum_r[55:0];
      e4_c = {1'b0, s3_e_r};
    end
    n4_pad = {n4_c, 8'd0};
    for (int c = 0; c < 4; c++) begin
      cl_c[c] = tvsf_pkg::lzc16(n4_pad[16*c +: 16]);
      nz_c[c] = |n4_pad[16*c +: 16];
    end
  end

  logic        s4_spec_r, s4_sgn_r, s4_zero_r;
  logic [63:0] s4_val_r;
  logic [11:0] s4_e_r;
  logic [55:0] s4_n_r;
  logic [3:0][3:0] s4_cl_r;
  logic [3:0]  s4_nz_r;

  // stage 5: normalize, stop at the subnormal boundary
  logic [11:0] lz5, lim5, sh5;
  assign lz5  = {6'd0, tvsf_pkg::lz_join(s4_cl_r, s4_nz_r)};
  assign lim5 = s4_e_r - 12'd1;
  assign sh5  = (lz5 < lim5) ? lz5 : lim5;

  logic        s5_spec_r, s5_sgn_r, s5_zero_r;
  logic [63:0] s5_val_r;
  logic [11:0] s5_e_r;
  logic [55:0] s5_n_r;

  // stage 6: round and pack
  logic        inc6;
  logic [53:0] r6;
  logic [52:0] mf6;
  logic [11:0] e6;
  logic [63:0] res6;
  always_comb begin
    inc6 = s5_n_r[2] && ((|s5_n_r[1:0]) || s5_n_r[3]);
    r6   = {1'b0, s5_n_r[55:3]} + {53'd0, inc6};
    if (r6[53]) begin
      mf6 = r6[53:1];
      e6  = s5_e_r + 12'd1;
    end else begin
      mf6 = r6[52:0];
      e6  = s5_e_r;
    end
    if (s5_spec_r)                res6 = s5_val_r;
    else if (s5_zero_r)           res6 = 64'd0;
    else if (e6 >= 12'd2047)      res6 = {s5_sgn_r, 11'h7FF, 52'd0};
    else if (mf6[52])             res6 = {s5_sgn_r, e6[10:0], mf6[51:0]};
    else                          res6 = {s5_sgn_r, 11'd0, mf6[51:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_spec_r <= spec_c;
      s1_val_r  <= sval_c;
      s1_sgn_r  <= swap ? bn[63] : a[63];
      s1_sub_r  <= a[63] ^ bn[63];
      s1_e_r    <= ebig;
      s1_diff_r <= ebig - esml;
      s1_mb_r   <= mbig;
      s1_ms_r   <= msml;

      s2_spec_r <= s1_spec_r;
      s2_val_r  <= s1_val_r;
      s2_sgn_r  <= s1_sgn_r;
      s2_sub_r  <= s1_sub_r;
      s2_e_r    <= s1_e_r;
      s2_ma_r   <= {s1_mb_r, 3'd0};
      s2_mb_r   <= al_c;

      s3_spec_r <= s2_spec_r;
      s3_val_r  <= s2_val_r;
      s3_sgn_r  <= s2_sgn_r;
      s3_e_r    <= s2_e_r;
      s3_sum_r  <= s2_sub_r ? ({1'b0, s2_ma_r} - {1'b0, s2_mb_r})
                            : ({1'b0, s2_ma_r} + {1'b0, s2_mb_r});

      s4_spec_r <= s3_spec_r;
      s4_val_r  <= s3_val_r;
      s4_sgn_r  <= s3_sgn_r;
      s4_zero_r <= (s3_sum_r == 57'd0);
      s4_e_r    <= e4_c;
      s4_n_r    <= n4_c;
      s4_cl_r   <= cl_c;
      s4_nz_r   <= nz_c;

      s5_spec_r <= s4_spec_r;
      s5_val_r  <= s4_val_r;
      s5_sgn_r  <= s4_sgn_r;
      s5_zero_r <= s4_zero_r;
      s5_e_r    <= s4_e_r - sh5;
      s5_n_r    <= s4_n_r << sh5[5:0];

      dout <= res6;
    end
  end

endmodule

// ----- hdl/tvsf_front.sv -----
// Front part: takes input words, masks them to the value type, checks the
// configuration and builds converter operands. Depends on tvsf_pkg, tvsf_in_if.
module tvsf_front (
  input  tvsf_pkg::cfg_t   cfg,
  tvsf_in_if.sink          in_ch,
  output logic             push_valid,
  input  logic             push_ready,
  output tvsf_pkg::item_t  push_item
);

  function automatic logic [63:0] type_mask(input logic [3:0] vt);
    logic [63:0] m;
    case (vt)
      tvsf_pkg::VT_U8,  tvsf_pkg::VT_I8:                  m = 64'h0000_0000_0000_00FF;
      tvsf_pkg::VT_U16, tvsf_pkg::VT_I16:                 m = 64'h0000_0000_0000_FFFF;
      tvsf_pkg::VT_U32, tvsf_pkg::VT_I32, tvsf_pkg::VT_F32: m = 64'h0000_0000_FFFF_FFFF;
      tvsf_pkg::VT_U64, tvsf_pkg::VT_I64, tvsf_pkg::VT_F64: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default:                                            m = 64'd0;
    endcase
    return m;
  endfunction

  function automatic tvsf_pkg::cvt_in_t make_cvt(input logic [63:0] raw,
                                                 input logic [3:0] vt,
                                                 input logic [63:0] msk);
    tvsf_pkg::cvt_in_t c;
    logic        sgnd, msb;
    logic [63:0] sx;
    sgnd = (vt >= tvsf_pkg::VT_I8) && (vt <= tvsf_pkg::VT_I64);
    case (vt)
      tvsf_pkg::VT_I8:  msb = raw[7];
      tvsf_pkg::VT_I16: msb = raw[15];
      tvsf_pkg::VT_I32: msb = raw[31];
      default:          msb = raw[63];
    endcase
    sx = raw | ((sgnd && msb) ? ~msk : 64'd0);
    c.sgn = sgnd && sx[63];
    c.mag = c.sgn ? (~sx + 64'd1) : sx;
    if (vt == tvsf_pkg::VT_F32) begin
      c.kind = tvsf_pkg::CK_F32;
      c.mag  = raw;
    end else if (vt == tvsf_pkg::VT_F64) begin
      c.kind = tvsf_pkg::CK_F64;
      c.mag  = raw;
    end else begin
      c.kind = tvsf_pkg::CK_INT;
    end
    return c;
  endfunction

  logic [63:0] msk, raw, nraw;
  logic        uses_prev, needle_opt;
  logic [3:0]  md;

  assign md         = cfg.comparison_mode;
  assign msk        = type_mask(cfg.value_type);
  assign raw        = in_ch.value_bits & msk;
  assign nraw       = cfg.needle_bits & msk;
  assign uses_prev  = (md >= tvsf_pkg::MODE_INC) && (md <= tvsf_pkg::MODE_UNCHANGED);
  assign needle_opt = (md == tvsf_pkg::MODE_UNKNOWN) || (md == tvsf_pkg::MODE_INC) ||
                      (md == tvsf_pkg::MODE_DEC) || (md == tvsf_pkg::MODE_CHG) ||
                      (md == tvsf_pkg::MODE_UNCHANGED);

  always_comb begin
    push_item.status = tvsf_pkg::ST_HIT;
    if (msk == 64'd0)
      push_item.status = tvsf_pkg::ST_BAD_TYPE;
    else if (!cfg.pass_kind && uses_prev)
      push_item.status = tvsf_pkg::ST_NEED_PREV;
    else if (!cfg.pass_kind && (md != tvsf_pkg::MODE_UNKNOWN) && !cfg.needle_valid)
      push_item.status = tvsf_pkg::ST_NEED_VAL;
    else if (cfg.pass_kind && !needle_opt && !cfg.needle_valid)
      push_item.status = tvsf_pkg::ST_NEED_VAL;
    push_item.read_ok  = in_ch.read_ok;
    push_item.use_prev = cfg.pass_kind && uses_prev;
    push_item.isf      = (cfg.value_type == tvsf_pkg::VT_F32) ||
                         (cfg.value_type == tvsf_pkg::VT_F64);
    push_item.mode     = md;
    push_item.address  = in_ch.address;
    push_item.raw      = raw;
    push_item.nraw     = nraw;
    push_item.prev     = in_ch.previous_value;
    push_item.cv       = make_cvt(raw, cfg.value_type, msk);
    push_item.cn       = make_cvt(nraw, cfg.value_type, msk);
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

// ----- hdl/tvsf_back.sv -----
// Back part: converts, subtracts, compares, counts hits and holds the result register.
// Depends on tvsf_pkg, tvsf_cvt, tvsf_fsub, tvsf_out_if and the assertion macros.
`include "typed_value_scan_filter_core_macros.svh"
module tvsf_back #(
  parameter int HIT_LIMIT = 1048576
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tvsf_pkg::cfg_t  cfg,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  tvsf_pkg::item_t pop_item,
  tvsf_out_if.source      out_ch
);

  localparam int CVT_LAT = 3;
  localparam int SUB_LAT = 6;
  localparam int CMP_AT  = CVT_LAT + SUB_LAT - 1;
  localparam int NS      = CMP_AT + 2;

  typedef struct packed {
    tvsf_pkg::item_t it;
    logic [63:0]     num;
    logic [63:0]     nnum;
    logic            match;
  } line_t;

  logic        adv;
  logic [NS-1:0] v_r;
  line_t       ln_r [NS];
  line_t       ln_nxt [NS];
  line_t       ln_in;
  logic [63:0] num_w, nnum_w, d_w;

  logic        out_v_r, out_lim_r;
  logic [1:0]  out_st_r;
  logic [31:0] out_addr_r;
  logic [63:0] out_raw_r, out_num_r;
  logic [20:0] cnt_r, cnt_nxt, cnt_inc, lim;
  logic        fin_r, fin_nxt;

  // whole line moves when the result register is free or being taken
  assign adv       = !out_v_r || out_ch.ready;
  assign pop_ready = adv;

  always_comb begin
    ln_in    = '0;
    ln_in.it = pop_item;
  end

  tvsf_cvt u_cvt_val (.clk(clk), .en(adv), .din(pop_item.cv), .dout(num_w));
  tvsf_cvt u_cvt_ndl (.clk(clk), .en(adv), .din(pop_item.cn), .dout(nnum_w));

  tvsf_fsub u_fsub (
    .clk (clk),
    .en  (adv),
    .a   (num_w),
    .b   (ln_r[CVT_LAT-1].it.prev),
    .dout(d_w)
  );

  // compare
  logic match_c;
  tvsf_pkg::item_t ci;
  logic [63:0] cn, cnn, cp;
  always_comb begin
    ci  = ln_r[CMP_AT].it;
    cn  = ln_r[CMP_AT].num;
    cnn = ln_r[CMP_AT].nnum;
    cp  = ci.prev;
    match_c = 1'b0;
    if (ci.use_prev) begin
      case (ci.mode)
        tvsf_pkg::MODE_INC:       match_c = tvsf_pkg::f_lt(cp, cn);
        tvsf_pkg::MODE_DEC:       match_c = tvsf_pkg::f_lt(cn, cp);
        tvsf_pkg::MODE_CHG:       match_c = !tvsf_pkg::f_eq(cn, cp);
        tvsf_pkg::MODE_UNCHANGED: match_c = tvsf_pkg::f_eq(cn, cp);
        tvsf_pkg::MODE_INC_BY:    match_c = tvsf_pkg::f_eq(d_w, cnn);
        tvsf_pkg::MODE_DEC_BY:    match_c = tvsf_pkg::f_eq({~d_w[63], d_w[62:0]}, cnn);
        tvsf_pkg::MODE_CHG_BY:    match_c = tvsf_pkg::f_eq({1'b0, d_w[62:0]}, cnn);
        default:                  match_c = 1'b0;
      endcase
    end else begin
      case (ci.mode)
        tvsf_pkg::MODE_UNKNOWN: match_c = 1'b1;
        tvsf_pkg::MODE_EQ:  match_c = ci.isf ? tvsf_pkg::f_eq(cn, cnn) : (ci.raw == ci.nraw);
        tvsf_pkg::MODE_NE:  match_c = ci.isf ? !tvsf_pkg::f_eq(cn, cnn) : (ci.raw != ci.nraw);
        tvsf_pkg::MODE_GT:  match_c = tvsf_pkg::f_lt(cnn, cn);
        tvsf_pkg::MODE_GTE: match_c = tvsf_pkg::f_lt(cnn, cn) || tvsf_pkg::f_eq(cn, cnn);
        tvsf_pkg::MODE_LT:  match_c = tvsf_pkg::f_lt(cn, cnn);
        tvsf_pkg::MODE_LTE: match_c = tvsf_pkg::f_lt(cn, cnn) || tvsf_pkg::f_eq(cn, cnn);
        default:            match_c = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], pop_valid};
    end
  end

  // next line: shift by one, converter and compare results land at their stages
  always_comb begin
    ln_nxt[0] = ln_in;
    for (int i = 1; i < NS; i++) ln_nxt[i] = ln_r[i-1];
    ln_nxt[CVT_LAT].num  = num_w;
    ln_nxt[CVT_LAT].nnum = nnum_w;
    ln_nxt[NS-1].match   = match_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NS; i++) ln_r[i] <= ln_nxt[i];
    end
  end

  // hit limit, clamped and never zero
  always_comb begin
    if (32'(cfg.max_hits) > 32'(HIT_LIMIT)) lim = 21'(HIT_LIMIT);
    else                                     lim = cfg.max_hits;
    if (lim == 21'd0) lim = 21'd1;
  end

  // final stage
  tvsf_pkg::item_t fi;
  logic        produce, lim_hit;
  assign fi      = ln_r[NS-1].it;
  assign cnt_inc = cnt_r + 21'd1;
  assign lim_hit = (cnt_inc >= lim);

  always_comb begin
    produce = 1'b0;
    cnt_nxt = cnt_r;
    fin_nxt = fin_r;
    if (v_r[NS-1] && !fin_r) begin
      if (fi.status != tvsf_pkg::ST_HIT) begin
        produce = 1'b1;
        fin_nxt = 1'b1;
      end else if (fi.read_ok && ln_r[NS-1].match) begin
        produce = 1'b1;
        cnt_nxt = cnt_inc;
        fin_nxt = lim_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
    end else if (adv) begin
      out_v_r <= produce;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && produce) begin
      out_st_r <= fi.status;
      if (fi.status != tvsf_pkg::ST_HIT) begin
        out_addr_r <= '0;
        out_raw_r  <= '0;
        out_num_r  <= '0;
        out_lim_r  <= 1'b0;
      end else begin
        out_addr_r <= fi.address;
        out_raw_r  <= fi.raw;
        out_num_r  <= ln_r[NS-1].num;
        out_lim_r  <= lim_hit;
      end
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.hit_address   = out_addr_r;
  assign out_ch.hit_raw       = out_raw_r;
  assign out_ch.hit_numeric   = out_num_r;
  assign out_ch.limit_reached = out_lim_r;

  `TVSF_ASSERT(a_fin_sticky, fin_r |=> fin_r, "finished flag dropped")
  `TVSF_ASSERT(a_limit_sets_fin, (out_v_r && out_lim_r) |-> fin_r, "limit hit without finish")
  `TVSF_ASSERT(a_err_clean, (out_v_r && (out_st_r != tvsf_pkg::ST_HIT)) |-> (!out_lim_r && (out_addr_r == 32'd0)), "error result carries payload")
  `TVSF_ASSERT(a_quiet_after_fin, (fin_r && !out_v_r) |=> !out_v_r, "result after finish")

endmodule

// ----- hdl/typed_value_scan_filter_core.sv -----
// Typed value scan filter, top level: configuration registers, front, queue, back.
// Depends on tvsf_pkg, the channel interfaces, tvsf_front, tvsf_fifo, tvsf_back.
//
// Usage:
//   cfg_ch  - register writes (index 0 value_type .. 5 max_hits), always ready.
//             Write only while no transaction is in flight.
//   in_ch   - one memory word per transaction; ready while the 4-entry queue has room.
//   out_ch  - hits and error statuses, at most one per input word, in input order.
// Throughput: one word per cycle sustained while out_ch.ready stays high.
// Path from input acceptance to out_ch.valid: the queue, the 3-stage to-double
//   converter, the 6-stage double subtractor, a compare stage and the result
//   register.
// Reset (rst_n low, synchronous): registers take their defaults, hit count and the
//   finished flag clear, the pipeline empties.
// Stalls: while out_ch.valid is high and out_ch.ready is low the back pipeline holds;
//   the queue absorbs up to four more words before in_ch.ready drops.
// After an error status or the hit that reaches the limit, every later word is
//   dropped until reset.
module typed_value_scan_filter_core #(
  parameter int HIT_LIMIT = 1048576
) (
  input logic        clk,
  input logic        rst_n,
  tvsf_cfg_if.sink   cfg_ch,
  tvsf_in_if.sink    in_ch,
  tvsf_out_if.source out_ch
);

  tvsf_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  // configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.value_type      <= tvsf_pkg::VT_U32;
      cfg_r.comparison_mode <= tvsf_pkg::MODE_UNKNOWN;
      cfg_r.pass_kind       <= 1'b0;
      cfg_r.needle_bits     <= 64'd0;
      cfg_r.needle_valid    <= 1'b0;
      cfg_r.max_hits        <= 21'd1024;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tvsf_pkg::CFG_VALUE_TYPE:   cfg_r.value_type      <= cfg_ch.data[3:0];
        tvsf_pkg::CFG_COMP_MODE:    cfg_r.comparison_mode <= cfg_ch.data[3:0];
        tvsf_pkg::CFG_PASS_KIND:    cfg_r.pass_kind       <= cfg_ch.data[0];
        tvsf_pkg::CFG_NEEDLE_BITS:  cfg_r.needle_bits     <= cfg_ch.data;
        tvsf_pkg::CFG_NEEDLE_VALID: cfg_r.needle_valid    <= cfg_ch.data[0];
        tvsf_pkg::CFG_MAX_HITS:     cfg_r.max_hits        <= cfg_ch.data[20:0];
        default: ;
      endcase
    end
  end

  // front -> queue
  logic            push_valid, push_ready;
  tvsf_pkg::item_t push_item;
  // queue -> back
  logic            pop_valid, pop_ready;
  tvsf_pkg::item_t pop_item;

  tvsf_front u_front (
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item)
  );

  tvsf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  tvsf_back #(.HIT_LIMIT(HIT_LIMIT)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_item (pop_item),
    .out_ch   (out_ch)
  );

endmodule
